// ----- design/adaptive_playout_delay_defines.svh -----
`ifndef ADAPTIVE_PLAYOUT_DELAY_DEFINES_SVH
`define ADAPTIVE_PLAYOUT_DELAY_DEFINES_SVH

// same-cycle implication, disabled in reset
`define APD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define APD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/apd_pkg.sv -----
`default_nettype none

package apd_pkg;

   localparam int FRAME_W    = 24;
   localparam int TIME_W     = 48;
   localparam int PERIOD_W   = 20;
   localparam int SHRINK_W   = 20;
   localparam int WLEN_W     = 10;
   localparam int OUT_W      = 32;
   localparam int LAG_OUT_W  = 33;
   localparam int LAG_W      = 34;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam int MAX_WINDOW = 512;
   localparam int WIN_AW     = $clog2(MAX_WINDOW);
   localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
   localparam int LEN_W      = (FILL_W > WLEN_W) ? FILL_W : WLEN_W;

   localparam int PROD_W = PERIOD_W + FRAME_W;
   localparam int ELAP_W = TIME_W + 1;
   localparam int EXP_W  = PROD_W + 2;
   localparam int DIFF_W = ELAP_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN   = 2'd2;

   localparam logic [PERIOD_W-1:0] RST_FRAME_PERIOD = 20'd33333;
   localparam logic [SHRINK_W-1:0] RST_SHRINK_STEP  = 20'd5000;
   localparam logic [WLEN_W-1:0]   RST_WINDOW_LEN   = 10'd300;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPECT,
      ST_DIFF,
      ST_PUSH,
      ST_SCAN,
      ST_FINISH
   } apd_state_type;

   typedef struct packed {
      logic load;
      logic expect_en;
      logic diff;
      logic push;
      logic scan;
      logic finish;
   } apd_cmd_type;

   typedef struct packed {
      logic scan_done;
   } apd_sts_type;

   // clamp a signed difference to the unsigned 32-bit range
   function automatic logic [OUT_W-1:0] sat32(input logic [DIFF_W-1:0] v);
      if (v[DIFF_W-1] || (v == '0)) begin
         return '0;
      end else if (|v[DIFF_W-2:OUT_W]) begin
         return '1;
      end else begin
         return v[OUT_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- design/apd_ctrl.sv -----
`default_nettype none

module apd_ctrl import apd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output apd_cmd_type      cmd,
   input  wire apd_sts_type sts
);

   apd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXPECT;
            end
         end
         ST_EXPECT: state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_PUSH;
         ST_PUSH:   state_in = ST_SCAN;
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd           = '0;
      req_stall     = (state_ff != ST_IDLE);
      cmd.load      = (state_ff == ST_IDLE) && req_valid;
      cmd.expect_en = (state_ff == ST_EXPECT);
      cmd.diff      = (state_ff == ST_DIFF);
      cmd.push      = (state_ff == ST_PUSH);
      cmd.scan      = (state_ff == ST_SCAN);
      cmd.finish    = (state_ff == ST_FINISH) && out_free;
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/apd_dpath.sv -----
`default_nettype none

module apd_dpath import apd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire apd_cmd_type           cmd,
   output apd_sts_type                sts,
   input  wire logic [FRAME_W-1:0]    req_frame_number,
   input  wire logic [TIME_W-1:0]     req_arrival_time_us,
   input  wire logic                  csr_wr,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [OUT_W-1:0]           rsp_wait_us,
   output logic [OUT_W-1:0]           rsp_lateness_us,
   output logic [LAG_OUT_W-1:0]       rsp_lag_us
);

   logic [PERIOD_W-1:0]      period_ff;
   logic [SHRINK_W-1:0]      shrink_ff;
   logic [WLEN_W-1:0]        wlen_ff;

   logic [TIME_W-1:0]        ref_ff, ref_in;
   logic signed [LAG_W-1:0]  lag_ff, lag_in;
   logic [WIN_AW-1:0]        head_ff, head_inc;
   logic [FILL_W-1:0]        fill_ff, fill_in, len_eff;
   logic [LEN_W-1:0]         wlen_ext;

   logic [PROD_W-1:0]        prod_ff;
   logic signed [ELAP_W-1:0] elap_ff;
   logic signed [EXP_W-1:0]  exp_ff;
   logic [DIFF_W-1:0]        diff_ff, ndiff_ff;
   logic [OUT_W-1:0]         late_ff, wait_ff, max_ff, late_in;

   logic [WIN_AW-1:0]        rd_addr_ff, rd_addr_dec, head_dec;
   logic [FILL_W-1:0]        rem_ff;
   logic                     rd_vld_ff;
   logic [OUT_W-1:0]         rd_data_ff;
   logic [OUT_W-1:0]         mem [MAX_WINDOW];

   logic signed [LAG_W-1:0]  max_s;
   logic [OUT_W-1:0]         wait_out_ff, late_out_ff;
   logic [LAG_OUT_W-1:0]     lag_out_ff;

   assign ref_in = (req_frame_number == '0) ? req_arrival_time_us : ref_ff;

   assign head_inc    = (head_ff == WIN_AW'(MAX_WINDOW - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec    = (head_ff == '0) ? WIN_AW'(MAX_WINDOW - 1) : head_ff - 1'b1;
   assign rd_addr_dec = (rd_addr_ff == '0) ? WIN_AW'(MAX_WINDOW - 1) : rd_addr_ff - 1'b1;

   assign wlen_ext = LEN_W'(wlen_ff);

   always_comb begin
      priority if (wlen_ext == '0) begin
         len_eff = FILL_W'(1);
      end else if (wlen_ext > LEN_W'(MAX_WINDOW)) begin
         len_eff = FILL_W'(MAX_WINDOW);
      end else begin
         len_eff = FILL_W'(wlen_ext);
      end
      if (LEN_W'(fill_ff) < LEN_W'(len_eff)) begin
         fill_in = fill_ff + 1'b1;
      end else begin
         fill_in = len_eff;
      end
   end

   assign late_in = sat32(diff_ff);
   assign max_s   = $signed({{(LAG_W - OUT_W){1'b0}}, max_ff});
   assign lag_in  = (lag_ff > max_s)
                  ? lag_ff - $signed({{(LAG_W - SHRINK_W){1'b0}}, shrink_ff})
                  : max_s;

   assign sts.scan_done = (rem_ff == '0) && !rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= RST_FRAME_PERIOD;
         shrink_ff <= RST_SHRINK_STEP;
         wlen_ff   <= RST_WINDOW_LEN;
         ref_ff    <= '0;
         lag_ff    <= '0;
         head_ff   <= '0;
         fill_ff   <= '0;
         rem_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               CSR_FRAME_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
               CSR_SHRINK_STEP:  shrink_ff <= csr_wdata[SHRINK_W-1:0];
               CSR_WINDOW_LEN:   wlen_ff   <= csr_wdata[WLEN_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            ref_ff <= ref_in;
         end
         if (cmd.push) begin
            head_ff   <= head_inc;
            fill_ff   <= fill_in;
            rem_ff    <= fill_in - 1'b1;
            rd_vld_ff <= 1'b0;
         end
         if (cmd.scan) begin
            if (rem_ff != '0) begin
               rem_ff    <= rem_ff - 1'b1;
               rd_vld_ff <= 1'b1;
            end else begin
               rd_vld_ff <= 1'b0;
            end
         end
         if (cmd.finish) begin
            lag_ff <= lag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         prod_ff <= PROD_W'(period_ff) * PROD_W'(req_frame_number);
         elap_ff <= $signed({1'b0, req_arrival_time_us}) - $signed({1'b0, ref_in});
      end
      if (cmd.expect_en) begin
         exp_ff <= $signed({2'b0, prod_ff})
                 + $signed({{(EXP_W - LAG_W){lag_ff[LAG_W-1]}}, lag_ff});
      end
      if (cmd.diff) begin
         diff_ff  <= {{(DIFF_W - ELAP_W){elap_ff[ELAP_W-1]}}, elap_ff}
                   - {{(DIFF_W - EXP_W){exp_ff[EXP_W-1]}}, exp_ff};
         ndiff_ff <= {{(DIFF_W - EXP_W){exp_ff[EXP_W-1]}}, exp_ff}
                   - {{(DIFF_W - ELAP_W){elap_ff[ELAP_W-1]}}, elap_ff};
      end
      if (cmd.push) begin
         late_ff    <= late_in;
         wait_ff    <= sat32(ndiff_ff);
         max_ff     <= late_in;
         rd_addr_ff <= head_dec;
      end
      if (cmd.scan) begin
         if (rem_ff != '0) begin
            rd_addr_ff <= rd_addr_dec;
         end
         if (rd_vld_ff && (rd_data_ff > max_ff)) begin
            max_ff <= rd_data_ff;
         end
      end
      if (cmd.finish) begin
         wait_out_ff <= wait_ff;
         late_out_ff <= late_ff;
         lag_out_ff  <= lag_in[LAG_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[head_ff] <= late_in;
      end
      if (cmd.scan) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   assign rsp_wait_us     = wait_out_ff;
   assign rsp_lateness_us = late_out_ff;
   assign rsp_lag_us      = lag_out_ff;

endmodule

`default_nettype wire

// ----- design/adaptive_playout_delay.sv -----
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  frame_number[24], arrival_time_us[48]
// rsp_      out        rsp_valid/rsp_stall  wait_us[32], lateness_us[32], lag_us[33]
// csr_      in         csr_valid/csr_ready  index[2], wdata[20]
//
// After acceptance the window maximum is found by one lateness memory read a cycle over a window
// of at most 512 entries; rsp_valid rises once the scan is done and the result is registered.
// One word in flight; the next is accepted while the result register waits to be taken.
// Reset is synchronous: registers take their default values, lag and reference clear.
// csr_ready is always high; write registers only while no word is in flight.
`default_nettype none

module adaptive_playout_delay import apd_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [FRAME_W-1:0]    req_frame_number,
   input  wire logic [TIME_W-1:0]     req_arrival_time_us,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [OUT_W-1:0]           rsp_wait_us,
   output logic [OUT_W-1:0]           rsp_lateness_us,
   output logic [LAG_OUT_W-1:0]       rsp_lag_us,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   apd_cmd_type cmd;
   apd_sts_type sts;
   logic        csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   apd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   apd_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_frame_number    (req_frame_number),
      .req_arrival_time_us (req_arrival_time_us),
      .csr_wr              (csr_wr),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_wait_us         (rsp_wait_us),
      .rsp_lateness_us     (rsp_lateness_us),
      .rsp_lag_us          (rsp_lag_us)
   );

endmodule

`default_nettype wire

// ----- design/apd_checker.sv -----
`default_nettype none
`include "adaptive_playout_delay_defines.svh"

module apd_checker import apd_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire logic [OUT_W-1:0]     rsp_wait_us,
   input wire logic [OUT_W-1:0]     rsp_lateness_us,
   input wire logic [LAG_OUT_W-1:0] rsp_lag_us
);

   // hold a stalled result word
   `APD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_wait_us) && $stable(rsp_lateness_us) && $stable(rsp_lag_us), "stalled result changed")

   // one word in flight: stall the input after acceptance
   `APD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "input not stalled while busy")

   // a frame is never both early and late
   `APD_ASSERT_NOW(a_wait_or_late, clock, reset, rsp_valid, (rsp_wait_us == '0) || (rsp_lateness_us == '0), "wait and lateness both non-zero")

   // a new result only comes out of a busy block
   `APD_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall), "result without a word in flight")

endmodule

bind adaptive_playout_delay apd_checker u_apd_checker (.*);

`default_nettype wire
